### rtl/fax_apt_sample_sequencer_defines.svh
// ----------------------------------------------------------------------------
// fax_apt_sample_sequencer_defines
// Assertion macros used by the sequencer top level.
// ----------------------------------------------------------------------------
`ifndef FAX_APT_SAMPLE_SEQUENCER_DEFINES_SVH
`define FAX_APT_SAMPLE_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FASS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`define FASS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define FASS_ASSERT_NEVER(lbl, expr, msg)
`define FASS_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

### rtl/fass_pkg.sv
// ----------------------------------------------------------------------------
// fass_pkg
// Types and constants of the radio-fax sample sequencer.
// ----------------------------------------------------------------------------
package fass_pkg;

  localparam int NW  = 36;  // sample count, covers the longest phase
  localparam int DVW = 48;  // divider dividend
  localparam int DSW = 23;  // divider divisor (60 * rate)
  localparam int QW  = 21;  // divider quotient

  localparam logic [4:0] QB_TONE = 5'd21;
  localparam logic [4:0] QB_LINE = 5'd12;

  localparam logic [2:0] CFG_LPM        = 3'd0;
  localparam logic [2:0] CFG_RATE       = 3'd1;
  localparam logic [2:0] CFG_START_FREQ = 3'd2;
  localparam logic [2:0] CFG_START_SECS = 3'd3;
  localparam logic [2:0] CFG_PH_LINES   = 3'd4;
  localparam logic [2:0] CFG_POLARITY   = 3'd5;
  localparam logic [2:0] CFG_STOP_FREQ  = 3'd6;
  localparam logic [2:0] CFG_STOP_SECS  = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_START    = 3'd1,
    PH_PHASING  = 3'd2,
    PH_ENDPHASE = 3'd3,
    PH_IMAGE    = 3'd4,
    PH_STOP     = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET1,
    ST_COMMIT,
    ST_DIV1,
    ST_FIN1,
    ST_SET2,
    ST_DIV2,
    ST_DIV3,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DS_SAMPLE,
    DS_LOC,
    DS_COL
  } dsel_t;

  typedef struct packed {
    logic  accept;
    logic  settle;
    logic  commit;
    logic  div_start;
    dsel_t div_sel;
    logic  fin;
    logic  frow_ld;
    logic  fcol_ld;
    logic  out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic   settled;
    logic   div_busy;
    logic   need_div;
    phase_t wph;
  } dp_stat_t;

endpackage

### rtl/fass_div.sv
// ----------------------------------------------------------------------------
// fass_div
// Restoring divider, one quotient bit per cycle, quotient width per request.
// ----------------------------------------------------------------------------
module fass_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fass_pkg::DVW-1:0]  dvd,
  input  logic [fass_pkg::DSW-1:0]  dvs,
  input  logic [4:0]                qbits,
  output logic                      busy,
  output logic [fass_pkg::QW-1:0]   quo,
  output logic [fass_pkg::DSW-1:0]  rem
);

  logic [fass_pkg::DVW-1:0] rem_r;
  logic [fass_pkg::DVW-1:0] dsh_r;
  logic [fass_pkg::QW-1:0]  quo_r;
  logic [4:0]               cnt_r;
  logic                     busy_r;
  logic                     ge;

  assign ge = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= qbits;
      rem_r  <= dvd;
      dsh_r  <= fass_pkg::DVW'(dvs) << (qbits - 5'd1);
      quo_r  <= '0;
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - dsh_r;
      quo_r  <= {quo_r[fass_pkg::QW-2:0], ge};
      dsh_r  <= dsh_r >> 1;
      cnt_r  <= cnt_r - 5'd1;
      busy_r <= (cnt_r != 5'd1);
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r[fass_pkg::DSW-1:0];

endmodule

### rtl/fass_ctrl.sv
// ----------------------------------------------------------------------------
// fass_ctrl
// Sequencer controller: settles phases, runs divisions, hands off results.
// ----------------------------------------------------------------------------
module fass_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_start,
  output logic                in_tready,
  input  logic                out_tready,
  output logic                out_tvalid,
  input  fass_pkg::dp_stat_t  st,
  output fass_pkg::dp_cmd_t   cmd
);

  fass_pkg::state_t state_r, state_nxt;
  logic             out_valid_r;
  logic             out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fass_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = in_start ? fass_pkg::ST_SET2 : fass_pkg::ST_SET1;
      end
      fass_pkg::ST_SET1: begin
        if (st.settled) state_nxt = fass_pkg::ST_COMMIT;
      end
      fass_pkg::ST_COMMIT: begin
        if (st.wph == fass_pkg::PH_IDLE) state_nxt = fass_pkg::ST_SET2;
        else if (st.need_div)            state_nxt = fass_pkg::ST_DIV1;
        else                             state_nxt = fass_pkg::ST_FIN1;
      end
      fass_pkg::ST_DIV1: begin
        if (!st.div_busy) state_nxt = fass_pkg::ST_FIN1;
      end
      fass_pkg::ST_FIN1: state_nxt = fass_pkg::ST_SET2;
      fass_pkg::ST_SET2: begin
        if (st.settled)
          state_nxt = (st.wph == fass_pkg::PH_IMAGE) ? fass_pkg::ST_DIV2 : fass_pkg::ST_DONE;
      end
      fass_pkg::ST_DIV2: begin
        if (!st.div_busy) state_nxt = fass_pkg::ST_DIV3;
      end
      fass_pkg::ST_DIV3: begin
        if (!st.div_busy) state_nxt = fass_pkg::ST_DONE;
      end
      fass_pkg::ST_DONE: begin
        if (out_free) state_nxt = fass_pkg::ST_IDLE;
      end
      default: state_nxt = fass_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.div_sel   = fass_pkg::DS_SAMPLE;
    in_tready     = 1'b0;
    case (state_r)
      fass_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      fass_pkg::ST_SET1: cmd.settle = 1'b1;
      fass_pkg::ST_COMMIT: begin
        cmd.commit    = 1'b1;
        cmd.div_start = st.need_div;
      end
      fass_pkg::ST_FIN1: cmd.fin = 1'b1;
      fass_pkg::ST_SET2: begin
        cmd.settle    = 1'b1;
        cmd.div_sel   = fass_pkg::DS_LOC;
        cmd.div_start = st.settled && (st.wph == fass_pkg::PH_IMAGE);
      end
      fass_pkg::ST_DIV2: begin
        // row is ready: keep it and divide the remainder for the column
        cmd.div_sel   = fass_pkg::DS_COL;
        cmd.frow_ld   = !st.div_busy;
        cmd.div_start = !st.div_busy;
      end
      fass_pkg::ST_DIV3: cmd.fcol_ld = !st.div_busy;
      fass_pkg::ST_DONE: cmd.out_ld = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fass_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_ld)     out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

### rtl/fass_dp.sv
// ----------------------------------------------------------------------------
// fass_dp
// Sequencer datapath: registers, phase lengths, operand select, result word.
// ----------------------------------------------------------------------------
module fass_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [16:0]         cfg_wdata,
  input  logic                in_start,
  input  logic [11:0]         in_rows,
  input  logic [11:0]         in_cols,
  input  logic [7:0]          in_gray,
  input  fass_pkg::dp_cmd_t   cmd,
  output fass_pkg::dp_stat_t  st,
  output logic                out_flag,
  output logic [47:0]         out_word
);

  // configuration
  logic [7:0]  lpm_r;
  logic [16:0] rate_r;
  logic [11:0] st_freq_r, sp_freq_r;
  logic [7:0]  st_secs_r, sp_secs_r, ph_lines_r;
  logic        pol_r;

  // transmission state and working copy
  fass_pkg::phase_t phase_r, wph_r, shown_r, wph_nxt;
  logic [fass_pkg::NW-1:0] n_r, wn_r;
  logic [11:0] rows_r, cols_r;
  logic [7:0]  pix_r;

  // result fields
  logic        valid_r;
  logic [7:0]  level_r;
  logic [11:0] line_r, fcol_r, frow_r;
  logic        oflag_r;
  logic [47:0] oword_r;

  logic [16:0] rate_e;
  logic [7:0]  lpm_e;
  logic [22:0] den;
  logic [11:0] sel12;
  logic [28:0] rp;
  logic [34:0] x60;
  logic [36:0] np1;
  logic [44:0] npl;
  logic        ge;
  logic        tone;
  logic [12:0] f2;
  logic [48:0] prod_tone;
  logic [43:0] prod_loc;
  logic [34:0] prod_col;
  logic [fass_pkg::DVW-1:0] dvd;
  logic [fass_pkg::DSW-1:0] dvs;
  logic [4:0]  qb;
  logic        div_busy;
  logic [fass_pkg::QW-1:0]  quo;
  logic [fass_pkg::DSW-1:0] rem;
  logic [28:0] m40, den39;
  logic [7:0]  edge_lvl, lvl;
  logic [fass_pkg::NW-1:0] n_inc;

  assign rate_e = (rate_r == '0) ? 17'd1 : rate_r;
  assign lpm_e  = (lpm_r == '0) ? 8'd1 : lpm_r;
  assign den    = 23'(rate_e) * 23'd60;

  // phase length test: R*k for tones, floor(60*R*k/L) <= n as 60*R*k < (n+1)*L
  always_comb begin
    case (wph_r)
      fass_pkg::PH_START:    sel12 = {4'd0, st_secs_r};
      fass_pkg::PH_PHASING:  sel12 = {4'd0, ph_lines_r};
      fass_pkg::PH_ENDPHASE: sel12 = 12'd1;
      fass_pkg::PH_IMAGE:    sel12 = rows_r;
      fass_pkg::PH_STOP:     sel12 = {4'd0, sp_secs_r};
      default:               sel12 = 12'd0;
    endcase
  end

  assign rp  = 29'(rate_e) * 29'(sel12);
  assign x60 = 35'(rp) * 35'd60;
  assign np1 = 37'(wn_r) + 37'd1;
  assign npl = 45'(np1) * 45'(lpm_e);

  always_comb begin
    case (wph_r)
      fass_pkg::PH_START, fass_pkg::PH_STOP: ge = wn_r >= fass_pkg::NW'(rp);
      fass_pkg::PH_PHASING, fass_pkg::PH_ENDPHASE, fass_pkg::PH_IMAGE:
        ge = 45'(x60) < npl;
      default: ge = 1'b0;
    endcase
  end

  assign wph_nxt = (wph_r == fass_pkg::PH_STOP) ? fass_pkg::PH_IDLE
                                                : fass_pkg::phase_t'(wph_r + 3'd1);

  // divider operands
  assign tone      = (wph_r == fass_pkg::PH_START) || (wph_r == fass_pkg::PH_STOP);
  assign f2        = {(wph_r == fass_pkg::PH_START) ? st_freq_r : sp_freq_r, 1'b0};
  assign prod_tone = 49'(wn_r) * 49'(f2);
  assign prod_loc  = 44'(wn_r) * 44'(lpm_e);
  assign prod_col  = 35'(rem) * 35'(cols_r);

  always_comb begin
    dvd = fass_pkg::DVW'(prod_loc);
    dvs = den;
    qb  = fass_pkg::QB_LINE;
    case (cmd.div_sel)
      fass_pkg::DS_SAMPLE: begin
        if (tone) begin
          dvd = prod_tone[fass_pkg::DVW-1:0];
          dvs = fass_pkg::DSW'(rate_e);
          qb  = fass_pkg::QB_TONE;
        end
      end
      fass_pkg::DS_COL: dvd = fass_pkg::DVW'(prod_col);
      default: ;
    endcase
  end

  fass_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .dvd   (dvd),
    .dvs   (dvs),
    .qbits (qb),
    .busy  (div_busy),
    .quo   (quo),
    .rem   (rem)
  );

  // sample level from the committed phase
  assign m40      = 29'(rem) * 29'd40;
  assign den39    = 29'(den) * 29'd39;
  assign edge_lvl = pol_r ? 8'd255 : 8'd0;

  always_comb begin
    case (phase_r)
      fass_pkg::PH_START, fass_pkg::PH_STOP: lvl = {8{quo[0]}};
      fass_pkg::PH_PHASING:
        lvl = (m40 < 29'(den) || m40 >= den39) ? edge_lvl : ~edge_lvl;
      fass_pkg::PH_ENDPHASE: lvl = edge_lvl;
      fass_pkg::PH_IMAGE:    lvl = pix_r;
      default:               lvl = 8'd0;
    endcase
  end

  assign n_inc = n_r + fass_pkg::NW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpm_r      <= 8'd120;
      rate_r     <= 17'd8000;
      st_freq_r  <= '0;
      st_secs_r  <= '0;
      ph_lines_r <= '0;
      pol_r      <= 1'b0;
      sp_freq_r  <= '0;
      sp_secs_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fass_pkg::CFG_LPM:        lpm_r      <= cfg_wdata[7:0];
        fass_pkg::CFG_RATE:       rate_r     <= cfg_wdata;
        fass_pkg::CFG_START_FREQ: st_freq_r  <= cfg_wdata[11:0];
        fass_pkg::CFG_START_SECS: st_secs_r  <= cfg_wdata[7:0];
        fass_pkg::CFG_PH_LINES:   ph_lines_r <= cfg_wdata[7:0];
        fass_pkg::CFG_POLARITY:   pol_r      <= cfg_wdata[0];
        fass_pkg::CFG_STOP_FREQ:  sp_freq_r  <= cfg_wdata[11:0];
        fass_pkg::CFG_STOP_SECS:  sp_secs_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fass_pkg::PH_IDLE;
      n_r     <= '0;
      rows_r  <= '0;
      cols_r  <= '0;
    end else if (cmd.accept && in_start) begin
      phase_r <= fass_pkg::PH_START;
      n_r     <= '0;
      rows_r  <= in_rows;
      cols_r  <= in_cols;
    end else if (cmd.commit) begin
      phase_r <= wph_r;
      n_r     <= wn_r;
    end else if (cmd.fin) begin
      n_r <= n_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      wph_r   <= in_start ? fass_pkg::PH_START : phase_r;
      wn_r    <= in_start ? '0 : n_r;
      pix_r   <= in_gray;
      shown_r <= fass_pkg::PH_IDLE;
      valid_r <= 1'b0;
      level_r <= '0;
      line_r  <= '0;
      fcol_r  <= '0;
      frow_r  <= '0;
    end else begin
      if (cmd.settle && !st.settled) begin
        wph_r <= wph_nxt;
        wn_r  <= '0;
      end
      if (cmd.commit) shown_r <= wph_r;
      if (cmd.fin) begin
        valid_r <= 1'b1;
        level_r <= lvl;
        line_r  <= (phase_r == fass_pkg::PH_IMAGE) ? quo[11:0] : 12'd0;
        wn_r    <= n_inc;
      end
      if (cmd.frow_ld) frow_r <= quo[11:0];
      if (cmd.fcol_ld) fcol_r <= quo[11:0];
    end
  end

  // result word, lowest field first: level, phase_now, image_line, fetch_col, fetch_row
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      oflag_r <= valid_r;
      oword_r <= {1'b0, frow_r, fcol_r, line_r, valid_r ? shown_r : wph_r, level_r};
    end
  end

  assign st.settled  = (wph_r == fass_pkg::PH_IDLE) || !ge;
  assign st.div_busy = div_busy;
  assign st.need_div = (wph_r != fass_pkg::PH_IDLE) && (wph_r != fass_pkg::PH_ENDPHASE);
  assign st.wph      = wph_r;
  assign out_flag    = oflag_r;
  assign out_word    = oword_r;

endmodule

### rtl/fax_apt_sample_sequencer.sv
// ----------------------------------------------------------------------------
// fax_apt_sample_sequencer
// Radio-fax baseband sequencer: one level per tick word, start/phasing/endphase/image/stop.
// ----------------------------------------------------------------------------
// Usage: each input word is a tick (in_tuser 0) or a start (in_tuser 1, with
// image rows and columns). Every input word yields exactly one output word:
// out_tuser flags a produced sample, out_tdata carries level, phase, image
// line and the pixel to present with the next tick (fetch column/row).
// Configuration is written through cfg_we/cfg_index/cfg_wdata while no word
// is in flight; there is no read-back.
// Each word is processed from the accepting cycle to the output load, one word
// at a time, through the phase settling (one phase per cycle) and a shared
// restoring divider that delivers one quotient bit per cycle: 21 bits for
// tone samples, 12 bits for the line position, then 12 bits each for the
// fetch row and column when the next sample is an image sample.
// A finished word sits in the output register; the next input word is taken
// while it waits, and its result is held back until the receiver drains it.
// Reset (rst_n low, synchronous) puts the block idle and loads the default
// register values (120 lines per minute, 8000 samples per second).
// ----------------------------------------------------------------------------
`include "fax_apt_sample_sequencer_defines.svh"

module fax_apt_sample_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // image_rows[11:0], image_cols[23:12], pixel_gray[31:24]
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // level[7:0], phase_now[10:8], image_line[22:11],
                                  // fetch_col[34:23], fetch_row[46:35]
  output logic        out_tuser   // sample_valid
);

  fass_pkg::dp_cmd_t  cmd;
  fass_pkg::dp_stat_t st;

  fass_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_start   (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .st         (st),
    .cmd        (cmd)
  );

  fass_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_start  (in_tuser),
    .in_rows   (in_tdata[11:0]),
    .in_cols   (in_tdata[23:12]),
    .in_gray   (in_tdata[31:24]),
    .cmd       (cmd),
    .st        (st),
    .out_flag  (out_tuser),
    .out_word  (out_tdata)
  );

  `FASS_ASSERT_NEVER(a_accept_busy, in_tready && st.div_busy, "input taken while dividing")
  `FASS_ASSERT_IMP(a_sample_phase, out_tvalid && out_tuser, (out_tdata[10:8] != fass_pkg::PH_IDLE) && (out_tdata[10:8] <= fass_pkg::PH_STOP), "sample without active phase")
  `FASS_ASSERT_IMP(a_line_no_sample, out_tvalid && !out_tuser, out_tdata[22:11] == 12'd0, "image line set without sample")

endmodule

### tb/fax_apt_sample_sequencer_checker.sv
// ----------------------------------------------------------------------------
// fax_apt_sample_sequencer_checker
// Watches the config port and both streams, predicts every output word of
// the sequencer from the accepted input words, and compares field by field.
// ----------------------------------------------------------------------------
module fax_apt_sample_sequencer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        out_tuser,
  output int          errors,
  output int          pending,
  output logic        tx_active
);

  typedef struct {
    logic        smp;
    logic [7:0]  level;
    logic [2:0]  ph;
    logic [11:0] line;
    logic [11:0] fcol;
    logic [11:0] frow;
  } sample_word_t;

  sample_word_t expected_q[$];

  // shadow registers
  logic [7:0]  lpm;
  logic [16:0] rate;
  logic [11:0] start_freq, stop_freq;
  logic [7:0]  start_secs, stop_secs, ph_lines;
  logic        polarity;
  // shadow state
  fass_pkg::phase_t cur_ph;
  logic [63:0] n_smp;
  logic [11:0] rows_q, cols_q;

  function automatic logic [63:0] eff_rate();
    return (rate == 0) ? 64'd1 : 64'(rate);
  endfunction

  function automatic logic [63:0] eff_lpm();
    return (lpm == 0) ? 64'd1 : 64'(lpm);
  endfunction

  function automatic logic [63:0] phase_len(fass_pkg::phase_t p);
    logic [63:0] r, l;
    r = eff_rate();
    l = eff_lpm();
    case (p)
      fass_pkg::PH_START:    return r * start_secs;
      fass_pkg::PH_PHASING:  return r * ph_lines * 60 / l;
      fass_pkg::PH_ENDPHASE: return r * 60 / l;
      fass_pkg::PH_IMAGE:    return r * rows_q * 60 / l;
      fass_pkg::PH_STOP:     return r * stop_secs;
      default:               return 0;
    endcase
  endfunction

  task automatic advance_phase(inout fass_pkg::phase_t p, inout logic [63:0] n);
    while (p != fass_pkg::PH_IDLE && n >= phase_len(p)) begin
      p = (p == fass_pkg::PH_STOP) ? fass_pkg::PH_IDLE : fass_pkg::phase_t'(p + 3'd1);
      n = 0;
    end
  endtask

  // line number and position inside the line, as the fraction m / (60 R)
  task automatic line_pos(input logic [63:0] n, output logic [63:0] row,
                          output logic [63:0] col, output logic [63:0] m);
    logic [63:0] den, prod;
    den  = 60 * eff_rate();
    prod = n * eff_lpm();
    m    = prod % den;
    row  = prod / den;
    col  = m * cols_q / den;
  endtask

  function automatic logic [7:0] square(logic [63:0] n, logic [11:0] f);
    return ((n * 2 * f / eff_rate()) & 1) ? 8'hff : 8'h00;
  endfunction

  task automatic predict_word(input logic cmd, input logic [31:0] d);
    sample_word_t     e;
    fass_pkg::phase_t nph;
    logic [63:0]      nn, row, col, m, den;
    logic [7:0]       edge_lvl;
    e = '{smp: 1'b0, level: 8'd0, ph: 3'd0, line: 12'd0, fcol: 12'd0, frow: 12'd0};
    if (cmd) begin
      rows_q = d[11:0];
      cols_q = d[23:12];
      cur_ph = fass_pkg::PH_START;
      n_smp  = 0;
    end else begin
      advance_phase(cur_ph, n_smp);
      e.ph = cur_ph;
      if (cur_ph != fass_pkg::PH_IDLE) begin
        den      = 60 * eff_rate();
        edge_lvl = polarity ? 8'hff : 8'h00;
        e.smp    = 1'b1;
        case (cur_ph)
          fass_pkg::PH_START: e.level = square(n_smp, start_freq);
          fass_pkg::PH_PHASING: begin
            line_pos(n_smp, row, col, m);
            e.level = (40 * m < den || 40 * m >= 39 * den) ? edge_lvl : ~edge_lvl;
          end
          fass_pkg::PH_ENDPHASE: e.level = edge_lvl;
          fass_pkg::PH_IMAGE: begin
            line_pos(n_smp, row, col, m);
            e.level = d[31:24];
            e.line  = row[11:0];
          end
          default: e.level = square(n_smp, stop_freq);
        endcase
        n_smp = (n_smp + 1) & 64'hffff_ffff_ffff;
      end
    end
    nph = cur_ph;
    nn  = n_smp;
    advance_phase(nph, nn);
    if (!e.smp) e.ph = nph;
    if (nph == fass_pkg::PH_IMAGE) begin
      line_pos(nn, row, col, m);
      e.fcol = col[11:0];
      e.frow = row[11:0];
    end
    expected_q.push_back(e);
  endtask

  task automatic check_word();
    sample_word_t e;
    if (expected_q.size() == 0) begin
      $error("output word with no prediction pending");
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (out_tuser !== e.smp) begin
      $error("sample_valid exp %0d got %0d", e.smp, out_tuser); errors++;
    end
    if (out_tdata[7:0] !== e.level) begin
      $error("level exp %0d got %0d", e.level, out_tdata[7:0]); errors++;
    end
    if (out_tdata[10:8] !== e.ph) begin
      $error("phase_now exp %0d got %0d", e.ph, out_tdata[10:8]); errors++;
    end
    if (out_tdata[22:11] !== e.line) begin
      $error("image_line exp %0d got %0d", e.line, out_tdata[22:11]); errors++;
    end
    if (out_tdata[34:23] !== e.fcol) begin
      $error("fetch_col exp %0d got %0d", e.fcol, out_tdata[34:23]); errors++;
    end
    if (out_tdata[46:35] !== e.frow) begin
      $error("fetch_row exp %0d got %0d", e.frow, out_tdata[46:35]); errors++;
    end
  endtask

  initial begin
    errors    = 0;
    pending   = 0;
    tx_active = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      lpm = 8'd120; rate = 17'd8000;
      start_freq = '0; start_secs = '0; ph_lines = '0; polarity = 1'b0;
      stop_freq = '0; stop_secs = '0;
      cur_ph = fass_pkg::PH_IDLE; n_smp = 0; rows_q = '0; cols_q = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fass_pkg::CFG_LPM:        lpm        = cfg_wdata[7:0];
          fass_pkg::CFG_RATE:       rate       = cfg_wdata;
          fass_pkg::CFG_START_FREQ: start_freq = cfg_wdata[11:0];
          fass_pkg::CFG_START_SECS: start_secs = cfg_wdata[7:0];
          fass_pkg::CFG_PH_LINES:   ph_lines   = cfg_wdata[7:0];
          fass_pkg::CFG_POLARITY:   polarity   = cfg_wdata[0];
          fass_pkg::CFG_STOP_FREQ:  stop_freq  = cfg_wdata[11:0];
          fass_pkg::CFG_STOP_SECS:  stop_secs  = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_word(in_tuser, in_tdata);
      if (out_tvalid && out_tready) check_word();
    end
    pending   <= expected_q.size();
    tx_active <= (cur_ph != fass_pkg::PH_IDLE);
  end

endmodule

### tb/fax_apt_sample_sequencer_tb.sv
// ----------------------------------------------------------------------------
// fax_apt_sample_sequencer_tb
// Drives config sets and start/tick words into the sequencer with random
// stalls on both streams; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
module fax_apt_sample_sequencer_tb;

  localparam int IDLE_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_wdata;
  logic        in_tvalid, in_tready, in_tuser;
  logic [31:0] in_tdata;
  logic        out_tvalid, out_tready, out_tuser;
  logic [47:0] out_tdata;
  int          errors, pending;
  logic        tx_active;

  int  mode;        // 0: sender 20% / receiver 66%, 1: reversed, 2: no idling
  int  out_seen;
  int  quiet_cycles;

  fax_apt_sample_sequencer uut (.*);

  fax_apt_sample_sequencer_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random backpressure plus one long hold-off
  initial begin
    int hold;
    out_tready = 1'b0;
    out_seen   = 0;
    hold       = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) out_seen++;
      if (out_seen == 300 && hold == 0) hold = 400;
      if (hold > 1) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        if (hold == 1 && out_seen != 300) hold = 0;
        case (mode)
          0:       out_tready <= ($urandom_range(0, 99) >= 66);
          1:       out_tready <= ($urandom_range(0, 99) >= 20);
          default: out_tready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [16:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(input int lp, input int r, input int sf, input int ss,
                           input int pl, input int pol, input int tf, input int ts);
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    cfg_write(fass_pkg::CFG_LPM, 17'(lp));
    cfg_write(fass_pkg::CFG_RATE, 17'(r));
    cfg_write(fass_pkg::CFG_START_FREQ, 17'(sf));
    cfg_write(fass_pkg::CFG_START_SECS, 17'(ss));
    cfg_write(fass_pkg::CFG_PH_LINES, 17'(pl));
    cfg_write(fass_pkg::CFG_POLARITY, 17'(pol));
    cfg_write(fass_pkg::CFG_STOP_FREQ, 17'(tf));
    cfg_write(fass_pkg::CFG_STOP_SECS, 17'(ts));
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(input logic cmd, input logic [31:0] d);
    int gap;
    gap = 0;
    if (mode == 0 && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 6);
    if (mode == 1 && $urandom_range(0, 99) < 66) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_start(input int rows, input int cols);
    send_word(1'b1, {8'($urandom), 12'(cols), 12'(rows)});
  endtask

  task automatic send_tick();
    send_word(1'b0, $urandom);
  endtask

  initial begin
    int rows, cols, r;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tuser  = 1'b0;
    in_tdata  = '0;
    mode      = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick, then a short full transmission with 4-sample lines
    send_tick();
    in_tvalid <= 1'b0;
    load_regs(60, 4, 1, 1, 2, 1, 4095, 1);
    send_start(2, 4095);
    repeat (14) send_tick();
    send_start(2, 0);   // restart mid-run, zero image width
    repeat (30) send_tick();
    in_tvalid <= 1'b0;

    for (int p = 0; p < 10; p++) begin
      mode = (p < 3) ? 0 : (p < 6) ? 1 : 2;
      case (p)
        0: load_regs(0, 0, 4095, 255, 255, 0, 0, 0);
        1: load_regs(255, 131071, 0, 0, 0, 1, 0, 0);
        2: load_regs(255, 1, 1, 2, 255, 1, 1, 255);
        default: begin
          r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071)
                                          : $urandom_range(1, 40);
          load_regs($urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                              : $urandom_range(30, 255),
                    r, $urandom_range(0, 4095), $urandom_range(0, 3),
                    $urandom_range(0, 3), $urandom_range(0, 1),
                    $urandom_range(0, 4095), $urandom_range(0, 3));
        end
      endcase
      send_start($urandom_range(0, 4), $urandom_range(1, 4095));
      for (int i = 0; i < 150; i++) begin
        if (!tx_active || $urandom_range(0, 99) < 2) begin
          rows = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                             : $urandom_range(0, 4);
          cols = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4095);
          send_start(rows, cols);
        end else begin
          send_tick();
        end
      end
      // sender holds until every result is back
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
    end

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/fass_pkg.sv
rtl/fass_div.sv
rtl/fass_ctrl.sv
rtl/fass_dp.sv
rtl/fax_apt_sample_sequencer.sv
tb/fax_apt_sample_sequencer_checker.sv
tb/fax_apt_sample_sequencer_tb.sv
